>>> rtl/kdrq_pkg.sv
// shared types and codes for the keypad debounce and event queue core
package kdrq_pkg;

  // operation codes
  localparam logic [1:0] OP_SCAN    = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // event action codes
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_REPEAT  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_MAX = 2'd0;
  localparam logic [1:0] CFG_REPEAT_DELAY = 2'd1;
  localparam logic [1:0] CFG_REPEAT_INTVL = 2'd2;
  localparam logic [1:0] CFG_REPEAT_MASK  = 2'd3;

  // configuration register reset values
  localparam logic [7:0]  DEBOUNCE_RST = 8'd4;
  localparam logic [31:0] DELAY_RST    = 32'd500;
  localparam logic [31:0] INTVL_RST    = 32'd100;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  scan_row;
    logic [7:0]  pressed_columns;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic        event_valid;
    logic [2:0]  event_row;
    logic [2:0]  event_col;
    logic [1:0]  event_action;
    logic [4:0]  queued_events;
    logic [31:0] overflow_total;
    logic [7:0]  active_columns;
  } out_t;

  // queue entry: row, column, action
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic [1:0] act;
  } entry_t;

endpackage

>>> rtl/keypad_debounce_repeat_queue_core.sv
// keypad matrix debounce, auto-repeat and bounded event queue, top level
//
// Usage: one transaction on in_* is one operation (scan one row, poll one
// event, force release of all keys, clear). Each accepted transaction gives
// exactly one result transaction on out_*. Registers are written through
// cfg_we/cfg_index/cfg_data while the block is idle.
// Work: a sequencer walks the work one step at a time. A scan visits each
// column of the row in turn, plus any queue push; a release pushed into a
// full queue runs one to three passes over the queue, a press or repeat
// is dropped. A poll runs one pass over the queued entries (the single-port
// queue memory is compacted in place). Force release walks every key plus
// pushes. Only one transaction is in work at a time; in_ready is high
// whenever the sequencer is idle.
// Reset (synchronous, rst_n low) clears all key state, the queue count,
// the overflow count and loads the register defaults; no clearing pass.
// A result waits in the output register while out_ready is low; a new
// transaction may be accepted meanwhile, but its result is held back until
// the previous one has been taken.
module keypad_debounce_repeat_queue_core #(
  parameter int ROWS        = 8,
  parameter int COLUMNS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kdrq_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kdrq_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  localparam int NK  = ROWS * COLUMNS;
  localparam int KW  = (NK > 1) ? $clog2(NK) : 1;
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SC_RD  = 5'd1;
  localparam logic [4:0] S_SC_EV  = 5'd2;
  localparam logic [4:0] S_SC_PRS = 5'd3;
  localparam logic [4:0] S_SC_REP = 5'd4;
  localparam logic [4:0] S_SC_NXT = 5'd5;
  localparam logic [4:0] S_PU_GO  = 5'd6;
  localparam logic [4:0] S_PU_DRP = 5'd7;
  localparam logic [4:0] S_PU_REP = 5'd8;
  localparam logic [4:0] S_PU_UND = 5'd9;
  localparam logic [4:0] S_F_RD   = 5'd10;
  localparam logic [4:0] S_F_EV   = 5'd11;
  localparam logic [4:0] S_FR_KEY = 5'd12;
  localparam logic [4:0] S_FR_NXT = 5'd13;
  localparam logic [4:0] S_FR_END = 5'd14;
  localparam logic [4:0] S_POLL   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // queue pass modes
  localparam logic [1:0] F_DROP = 2'd0;
  localparam logic [1:0] F_EREP = 2'd1;
  localparam logic [1:0] F_EUND = 2'd2;
  localparam logic [1:0] F_POP  = 2'd3;

  // configuration registers
  logic [7:0]    dmax_r;
  logic [31:0]   delay_r;
  logic [31:0]   intvl_r;
  logic [NK-1:0] mask_r;

  // per-key flag vectors
  logic [NK-1:0] raw_r, deb_r, started_r, sup_r, inh_r, disp_r, ivld_r;

  // memories
  logic [7:0]  integ_mem [NK];
  logic [31:0] time_mem [NK];
  logic [7:0]  integ_rd;
  logic [31:0] time_rd;
  kdrq_pkg::entry_t q_mem [QUEUE_DEPTH];
  kdrq_pkg::entry_t q_rd;

  // control
  logic [4:0]    state_r, ret_r, fret_r;
  logic [1:0]    op_r, fmode_r;
  logic [2:0]    row_r;
  logic [7:0]    cols_r;
  logic [31:0]   now_r, tcur_r;
  logic [KW-1:0] key_r;
  logic [RW-1:0] frow_r;
  logic [CLW-1:0] col_r;
  logic [CW-1:0] count_r, rd_r, wr_r;
  logic [31:0]   ovf_r;
  logic          push_ok_r, rm_r, got_r, ev_vld_r;
  kdrq_pkg::entry_t e_r, ev_r;
  logic          out_valid_r;
  kdrq_pkg::out_t out_r;

  // combinational helpers
  logic          q_we, i_we, t_we;
  logic [AW-1:0] q_wa;
  kdrq_pkg::entry_t q_wd;
  logic [7:0]    integ_cur, integ_new;
  logic          raw_bit, rm_cond, rep_fire;
  logic [KW-1:0] q_key;
  logic [7:0]    act_cols;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign q_key     = KW'(int'(q_rd.row) * COLUMNS + int'(q_rd.col));
  assign raw_bit   = cols_r[col_r];
  assign integ_cur = ivld_r[key_r] ? integ_rd : 8'd0;

  // integrator step
  always_comb begin
    integ_new = integ_cur;
    if (raw_bit) begin
      if (integ_cur < dmax_r) integ_new = integ_cur + 8'd1;
    end else if (integ_cur != 8'd0) begin
      integ_new = integ_cur - 8'd1;
    end
  end

  // repeat timer compare
  assign rep_fire = deb_r[key_r] && raw_r[key_r] && mask_r[key_r] &&
                    ((now_r - tcur_r) >= (started_r[key_r] ? intvl_r : delay_r));

  // queue pass removal decision
  always_comb begin
    case (fmode_r)
      F_DROP:  rm_cond = (q_rd.row == e_r.row) && (q_rd.col == e_r.col) &&
                         ((q_rd.act == kdrq_pkg::ACT_PRESS) ||
                          (q_rd.act == kdrq_pkg::ACT_REPEAT));
      F_EREP:  rm_cond = !rm_r && (q_rd.act == kdrq_pkg::ACT_REPEAT);
      F_EUND:  rm_cond = !rm_r && (q_rd.act == kdrq_pkg::ACT_PRESS) && !disp_r[q_key];
      F_POP:   rm_cond = (rd_r == '0);
      default: rm_cond = 1'b0;
    endcase
  end

  // memory write controls
  always_comb begin
    q_we = 1'b0;
    q_wa = count_r[AW-1:0];
    q_wd = e_r;
    i_we = 1'b0;
    t_we = 1'b0;
    case (state_r)
      S_PU_GO: begin
        if (count_r < CW'(QUEUE_DEPTH)) q_we = 1'b1;
      end
      S_PU_REP, S_PU_UND: begin
        if (rm_r && (count_r < CW'(QUEUE_DEPTH))) q_we = 1'b1;
      end
      S_F_EV: begin
        if (!rm_cond) begin
          q_we = 1'b1;
          q_wa = wr_r[AW-1:0];
          q_wd = q_rd;
        end
      end
      S_SC_EV: begin
        if (!inh_r[key_r]) begin
          i_we = 1'b1;
          if (!deb_r[key_r] && (integ_new == dmax_r)) t_we = 1'b1;
        end
      end
      S_SC_REP: begin
        t_we = rep_fire;
      end
      default: ;
    endcase
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (state_r == S_F_RD) q_rd <= q_mem[rd_r[AW-1:0]];
  end

  // integrator and repeat time memories
  always_ff @(posedge clk) begin
    if (i_we) integ_mem[key_r] <= integ_new;
    if (t_we) time_mem[key_r] <= now_r;
    if (state_r == S_SC_RD) begin
      integ_rd <= integ_mem[key_r];
      time_rd  <= time_mem[key_r];
    end
  end

  // debounced bits of the addressed row
  always_comb begin
    act_cols = 8'd0;
    for (int c = 0; c < COLUMNS; c++) begin
      if (int'(row_r) < ROWS) act_cols[c] = deb_r[KW'(int'(row_r) * COLUMNS + c)];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmax_r  <= kdrq_pkg::DEBOUNCE_RST;
      delay_r <= kdrq_pkg::DELAY_RST;
      intvl_r <= kdrq_pkg::INTVL_RST;
      mask_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        kdrq_pkg::CFG_DEBOUNCE_MAX: dmax_r  <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
        kdrq_pkg::CFG_REPEAT_DELAY: delay_r <= cfg_data[31:0];
        kdrq_pkg::CFG_REPEAT_INTVL: intvl_r <= cfg_data[31:0];
        kdrq_pkg::CFG_REPEAT_MASK:  mask_r  <= cfg_data[NK-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      raw_r       <= '0;
      deb_r       <= '0;
      started_r   <= '0;
      sup_r       <= '0;
      inh_r       <= '0;
      disp_r      <= '0;
      ivld_r      <= '0;
      count_r     <= '0;
      ovf_r       <= '0;
      out_valid_r <= 1'b0;
      ev_vld_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.operation;
            row_r    <= in_data.scan_row;
            cols_r   <= in_data.pressed_columns;
            now_r    <= in_data.now_ms;
            ev_vld_r <= 1'b0;
            case (in_data.operation)
              kdrq_pkg::OP_SCAN: begin
                col_r <= '0;
                frow_r <= RW'(in_data.scan_row);
                key_r <= KW'(int'(in_data.scan_row) * COLUMNS);
                state_r <= (int'(in_data.scan_row) < ROWS) ? S_SC_RD : S_DONE;
              end
              kdrq_pkg::OP_POLL: begin
                if (count_r != '0) begin
                  fmode_r <= F_POP;
                  fret_r  <= S_POLL;
                  rd_r    <= '0;
                  wr_r    <= '0;
                  rm_r    <= 1'b0;
                  got_r   <= 1'b0;
                  state_r <= S_F_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              kdrq_pkg::OP_RELEASE: begin
                count_r <= '0;
                key_r   <= '0;
                frow_r  <= '0;
                col_r   <= '0;
                state_r <= S_FR_KEY;
              end
              default: begin
                raw_r     <= '0;
                deb_r     <= '0;
                started_r <= '0;
                sup_r     <= '0;
                inh_r     <= '0;
                disp_r    <= '0;
                ivld_r    <= '0;
                count_r   <= '0;
                ovf_r     <= '0;
                state_r   <= S_DONE;
              end
            endcase
          end
        end

        // scan: read key memories
        S_SC_RD: state_r <= S_SC_EV;

        // scan: integrate and detect state change
        S_SC_EV: begin
          raw_r[key_r] <= raw_bit;
          // a new press restarts the repeat timer at the current time
          tcur_r <= (!inh_r[key_r] && !deb_r[key_r] && (integ_new == dmax_r)) ?
                    now_r : time_rd;
          e_r.row <= 3'(frow_r);
          e_r.col <= 3'(col_r);
          if (inh_r[key_r]) begin
            if (!raw_bit) begin
              inh_r[key_r]  <= 1'b0;
              ivld_r[key_r] <= 1'b0;
            end
            state_r <= S_SC_NXT;
          end else begin
            ivld_r[key_r] <= 1'b1;
            if (!deb_r[key_r] && (integ_new == dmax_r)) begin
              deb_r[key_r]     <= 1'b1;
              started_r[key_r] <= 1'b0;
              e_r.act <= kdrq_pkg::ACT_PRESS;
              ret_r   <= S_SC_PRS;
              state_r <= S_PU_GO;
            end else if (deb_r[key_r] && (integ_new == 8'd0)) begin
              deb_r[key_r]     <= 1'b0;
              started_r[key_r] <= 1'b0;
              sup_r[key_r]     <= 1'b0;
              e_r.act <= kdrq_pkg::ACT_RELEASE;
              ret_r   <= S_SC_REP;
              state_r <= sup_r[key_r] ? S_SC_REP : S_PU_GO;
            end else begin
              state_r <= S_SC_REP;
            end
          end
        end

        // scan: release is suppressed when the press was dropped
        S_SC_PRS: begin
          sup_r[key_r] <= !push_ok_r;
          state_r <= S_SC_REP;
        end

        // scan: auto-repeat timer
        S_SC_REP: begin
          if (rep_fire) begin
            started_r[key_r] <= 1'b1;
            e_r.act <= kdrq_pkg::ACT_REPEAT;
            ret_r   <= S_SC_NXT;
            state_r <= S_PU_GO;
          end else begin
            state_r <= S_SC_NXT;
          end
        end

        S_SC_NXT: begin
          if (int'(col_r) == COLUMNS - 1) begin
            state_r <= S_DONE;
          end else begin
            col_r   <= col_r + CLW'(1);
            key_r   <= key_r + KW'(1);
            state_r <= S_SC_RD;
          end
        end

        // push: append, or handle a full queue
        S_PU_GO: begin
          if (count_r < CW'(QUEUE_DEPTH)) begin
            count_r   <= count_r + CW'(1);
            push_ok_r <= 1'b1;
            state_r   <= ret_r;
          end else begin
            ovf_r     <= ovf_r + 32'd1;
            push_ok_r <= 1'b0;
            if (e_r.act != kdrq_pkg::ACT_RELEASE) begin
              state_r <= ret_r;
            end else begin
              fmode_r <= F_DROP;
              fret_r  <= S_PU_DRP;
              rd_r    <= '0;
              wr_r    <= '0;
              rm_r    <= 1'b0;
              got_r   <= 1'b0;
              state_r <= S_F_RD;
            end
          end
        end

        S_PU_DRP: begin
          if (got_r) begin
            state_r <= ret_r;
          end else begin
            fmode_r <= F_EREP;
            fret_r  <= S_PU_REP;
            rd_r    <= '0;
            wr_r    <= '0;
            rm_r    <= 1'b0;
            state_r <= S_F_RD;
          end
        end

        S_PU_REP: begin
          if (rm_r) begin
            if (count_r < CW'(QUEUE_DEPTH)) count_r <= count_r + CW'(1);
            state_r <= ret_r;
          end else begin
            fmode_r <= F_EUND;
            fret_r  <= S_PU_UND;
            rd_r    <= '0;
            wr_r    <= '0;
            state_r <= S_F_RD;
          end
        end

        S_PU_UND: begin
          if (rm_r && (count_r < CW'(QUEUE_DEPTH))) count_r <= count_r + CW'(1);
          state_r <= ret_r;
        end

        // queue pass: read one entry
        S_F_RD: begin
          if (rd_r == count_r) begin
            count_r <= wr_r;
            state_r <= fret_r;
          end else begin
            state_r <= S_F_EV;
          end
        end

        // queue pass: keep or remove the entry
        S_F_EV: begin
          if (rm_cond) begin
            rm_r <= 1'b1;
            if ((fmode_r == F_DROP) && (q_rd.act == kdrq_pkg::ACT_PRESS)) got_r <= 1'b1;
            if (fmode_r == F_EUND) sup_r[q_key] <= 1'b1;
            if (fmode_r == F_POP) begin
              ev_r     <= q_rd;
              ev_vld_r <= 1'b1;
            end
          end else begin
            wr_r <= wr_r + CW'(1);
          end
          rd_r    <= rd_r + CW'(1);
          state_r <= S_F_RD;
        end

        // force release: queue release for dispatched keys
        S_FR_KEY: begin
          e_r.row <= 3'(frow_r);
          e_r.col <= 3'(col_r);
          e_r.act <= kdrq_pkg::ACT_RELEASE;
          ret_r   <= S_FR_NXT;
          state_r <= (disp_r[key_r] && !sup_r[key_r]) ? S_PU_GO : S_FR_NXT;
        end

        S_FR_NXT: begin
          if (int'(key_r) == NK - 1) begin
            state_r <= S_FR_END;
          end else begin
            key_r <= key_r + KW'(1);
            if (int'(col_r) == COLUMNS - 1) begin
              col_r  <= '0;
              frow_r <= frow_r + RW'(1);
            end else begin
              col_r <= col_r + CLW'(1);
            end
            state_r <= S_FR_KEY;
          end
        end

        S_FR_END: begin
          inh_r     <= raw_r | deb_r;
          raw_r     <= '0;
          deb_r     <= '0;
          ivld_r    <= '0;
          started_r <= '0;
          sup_r     <= '0;
          state_r   <= S_DONE;
        end

        // poll: track dispatch of the popped event
        S_POLL: begin
          if (ev_r.act == kdrq_pkg::ACT_PRESS) begin
            disp_r[KW'(int'(ev_r.row) * COLUMNS + int'(ev_r.col))] <= 1'b1;
          end else if (ev_r.act == kdrq_pkg::ACT_RELEASE) begin
            disp_r[KW'(int'(ev_r.row) * COLUMNS + int'(ev_r.col))] <= 1'b0;
          end
          state_r <= S_DONE;
        end

        // result into the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_r.event_valid          <= ev_vld_r && (op_r == kdrq_pkg::OP_POLL);
            out_r.event_row            <= ev_vld_r ? ev_r.row : 3'd0;
            out_r.event_col            <= ev_vld_r ? ev_r.col : 3'd0;
            out_r.event_action         <= ev_vld_r ? ev_r.act : 2'd0;
            out_r.queued_events        <= 5'(count_r);
            out_r.overflow_total       <= ovf_r;
            out_r.active_columns       <= act_cols;
            state_r                    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/kdrq_chk.sv
// port-level checker for the keypad debounce core, with its bind
module kdrq_chk #(
  parameter int ROWS        = 8,
  parameter int COLUMNS     = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input kdrq_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input kdrq_pkg::out_t out_data,
  input logic           cfg_we,
  input logic [1:0]     cfg_index,
  input logic [63:0]    cfg_data
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // queue never reports more than its depth
  a_qdepth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.queued_events) <= QUEUE_DEPTH)
    else $error("queued_events above depth");

  // no event means zero event fields
  a_ev_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.event_valid |->
      out_data.event_row == 3'd0 && out_data.event_col == 3'd0 &&
      out_data.event_action == 2'd0)
    else $error("event fields set without event");

  // a popped event is a real key with a defined action
  a_ev_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_valid |->
      out_data.event_action != 2'd3 && int'(out_data.event_row) < ROWS &&
      int'(out_data.event_col) < COLUMNS)
    else $error("popped event out of range");

endmodule

bind keypad_debounce_repeat_queue_core kdrq_chk #(
  .ROWS(ROWS),
  .COLUMNS(COLUMNS),
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_kdrq_chk (.*);

>>> tb/keypad_debounce_repeat_queue_checker.sv
// transaction checker: mirrors the keypad core state and compares every result
module keypad_debounce_repeat_queue_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  kdrq_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  kdrq_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  output int             fail_count,
  output int             results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKEYS = 64;
  localparam int QDEPTH = 16;

  // mirrored registers
  logic [7:0]  dbnc_max;
  logic [31:0] rpt_delay;
  logic [31:0] rpt_intvl;
  logic [63:0] rpt_mask;

  // mirrored key state
  bit          k_raw [NKEYS];
  bit          k_down [NKEYS];
  logic [7:0]  k_integ [NKEYS];
  bit          k_rpt_started [NKEYS];
  bit          k_suppress [NKEYS];
  bit          k_inhibit [NKEYS];
  bit          k_dispatched [NKEYS];
  logic [31:0] k_last_rpt [NKEYS];
  kdrq_pkg::entry_t event_fifo [$];
  logic [31:0] overflow_cnt;

  kdrq_pkg::out_t expected_results [$];

  assign results_pending = expected_results.size();

  function automatic int key_of(kdrq_pkg::entry_t e);
    return e.row * 8 + e.col;
  endfunction

  function automatic void wipe_keys();
    for (int k = 0; k < NKEYS; k++) begin
      k_raw[k] = 0; k_down[k] = 0; k_integ[k] = '0; k_rpt_started[k] = 0;
      k_suppress[k] = 0; k_inhibit[k] = 0; k_dispatched[k] = 0; k_last_rpt[k] = '0;
    end
    event_fifo.delete();
    overflow_cnt = '0;
  endfunction

  // remove queued press/repeat of one key, report whether a press went
  function automatic bit drop_pending_press(int key);
    bit got;
    int i;
    got = 0;
    i = 0;
    while (i < event_fifo.size()) begin
      if (key_of(event_fifo[i]) == key &&
          (event_fifo[i].act == kdrq_pkg::ACT_PRESS ||
           event_fifo[i].act == kdrq_pkg::ACT_REPEAT)) begin
        if (event_fifo[i].act == kdrq_pkg::ACT_PRESS) got = 1;
        event_fifo.delete(i);
      end else begin
        i++;
      end
    end
    return got;
  endfunction

  function automatic bit evict_oldest_repeat();
    for (int i = 0; i < event_fifo.size(); i++)
      if (event_fifo[i].act == kdrq_pkg::ACT_REPEAT) begin
        event_fifo.delete(i);
        return 1;
      end
    return 0;
  endfunction

  function automatic bit evict_undispatched_press();
    int k;
    for (int i = 0; i < event_fifo.size(); i++) begin
      if (event_fifo[i].act != kdrq_pkg::ACT_PRESS) continue;
      k = key_of(event_fifo[i]);
      if (!k_dispatched[k]) begin
        k_suppress[k] = 1;
        event_fifo.delete(i);
        return 1;
      end
    end
    return 0;
  endfunction

  // enqueue with the overflow policy
  function automatic bit enqueue_event(int key, logic [1:0] act);
    kdrq_pkg::entry_t e;
    e.row = 3'(key / 8);
    e.col = 3'(key % 8);
    e.act = act;
    if (event_fifo.size() < QDEPTH) begin
      event_fifo.push_back(e);
      return 1;
    end
    overflow_cnt++;
    if (act != kdrq_pkg::ACT_RELEASE) return 0;
    if (drop_pending_press(key)) return 1;
    if (evict_oldest_repeat() || evict_undispatched_press()) begin
      if (event_fifo.size() < QDEPTH) event_fifo.push_back(e);
      return 1;
    end
    return 0;
  endfunction

  function automatic void key_transition(int k, bit down, logic [31:0] now);
    bit dummy;
    k_down[k] = down;
    k_rpt_started[k] = 0;
    if (down) begin
      k_last_rpt[k] = now;
      k_suppress[k] = !enqueue_event(k, kdrq_pkg::ACT_PRESS);
    end else begin
      if (!k_suppress[k]) dummy = enqueue_event(k, kdrq_pkg::ACT_RELEASE);
      k_suppress[k] = 0;
    end
  endfunction

  function automatic void scan_row_keys(int row, logic [7:0] cols, logic [31:0] now);
    int k;
    bit raw;
    bit dummy;
    logic [31:0] limit;
    for (int c = 0; c < 8; c++) begin
      k = row * 8 + c;
      raw = cols[c];
      k_raw[k] = raw;
      if (k_inhibit[k]) begin
        if (!raw) begin
          k_inhibit[k] = 0;
          k_integ[k] = '0;
        end
        continue;
      end
      if (raw) begin
        if (k_integ[k] < dbnc_max) k_integ[k]++;
      end else if (k_integ[k] > 0) begin
        k_integ[k]--;
      end
      if (!k_down[k] && k_integ[k] == dbnc_max) key_transition(k, 1, now);
      else if (k_down[k] && k_integ[k] == 0) key_transition(k, 0, now);
      if (!k_down[k] || !raw || !rpt_mask[k]) continue;
      limit = k_rpt_started[k] ? rpt_intvl : rpt_delay;
      if (32'(now - k_last_rpt[k]) >= limit) begin
        dummy = enqueue_event(k, kdrq_pkg::ACT_REPEAT);
        k_rpt_started[k] = 1;
        k_last_rpt[k] = now;
      end
    end
  endfunction

  function automatic void release_all_keys();
    bit was;
    bit dummy;
    event_fifo.delete();
    for (int k = 0; k < NKEYS; k++) begin
      was = k_raw[k] || k_down[k];
      if (k_dispatched[k] && !k_suppress[k])
        dummy = enqueue_event(k, kdrq_pkg::ACT_RELEASE);
      k_raw[k] = 0; k_down[k] = 0; k_integ[k] = '0;
      k_rpt_started[k] = 0; k_suppress[k] = 0; k_inhibit[k] = was;
    end
  endfunction

  // one operation of the keypad core, giving its result
  function automatic kdrq_pkg::out_t keypad_step(kdrq_pkg::in_t x);
    kdrq_pkg::out_t r;
    kdrq_pkg::entry_t e;
    r = '0;
    case (x.operation)
      kdrq_pkg::OP_SCAN: scan_row_keys(x.scan_row, x.pressed_columns, x.now_ms);
      kdrq_pkg::OP_POLL: begin
        if (event_fifo.size() > 0) begin
          e = event_fifo.pop_front();
          r.event_valid = 1'b1;
          r.event_row = e.row;
          r.event_col = e.col;
          r.event_action = e.act;
          if (e.act == kdrq_pkg::ACT_PRESS) k_dispatched[key_of(e)] = 1;
          else if (e.act == kdrq_pkg::ACT_RELEASE) k_dispatched[key_of(e)] = 0;
        end
      end
      kdrq_pkg::OP_RELEASE: release_all_keys();
      default: wipe_keys();
    endcase
    r.queued_events = 5'(event_fifo.size());
    r.overflow_total = overflow_cnt;
    for (int c = 0; c < 8; c++) r.active_columns[c] = k_down[x.scan_row * 8 + c];
    return r;
  endfunction

  always @(posedge clk) begin
    kdrq_pkg::out_t exp_r;
    if (!rst_n) begin
      wipe_keys();
      dbnc_max <= kdrq_pkg::DEBOUNCE_RST;
      rpt_delay <= kdrq_pkg::DELAY_RST;
      rpt_intvl <= kdrq_pkg::INTVL_RST;
      rpt_mask <= '0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // compare the result transaction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r != out_data) begin
            fail_count <= fail_count + 1;
            if (exp_r.event_valid != out_data.event_valid)
              $error("event_valid exp %0d got %0d", exp_r.event_valid, out_data.event_valid);
            if (exp_r.event_row != out_data.event_row)
              $error("event_row exp %0d got %0d", exp_r.event_row, out_data.event_row);
            if (exp_r.event_col != out_data.event_col)
              $error("event_col exp %0d got %0d", exp_r.event_col, out_data.event_col);
            if (exp_r.event_action != out_data.event_action)
              $error("event_action exp %0d got %0d", exp_r.event_action,
                     out_data.event_action);
            if (exp_r.queued_events != out_data.queued_events)
              $error("queued_events exp %0d got %0d", exp_r.queued_events,
                     out_data.queued_events);
            if (exp_r.overflow_total != out_data.overflow_total)
              $error("overflow_total exp %0d got %0d", exp_r.overflow_total,
                     out_data.overflow_total);
            if (exp_r.active_columns != out_data.active_columns)
              $error("active_columns exp %h got %h", exp_r.active_columns,
                     out_data.active_columns);
          end
        end
      end
      // predict the input transaction
      if (in_valid && in_ready) expected_results.push_back(keypad_step(in_data));
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          kdrq_pkg::CFG_DEBOUNCE_MAX:
            dbnc_max <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
          kdrq_pkg::CFG_REPEAT_DELAY: rpt_delay <= cfg_data[31:0];
          kdrq_pkg::CFG_REPEAT_INTVL: rpt_intvl <= cfg_data[31:0];
          kdrq_pkg::CFG_REPEAT_MASK:  rpt_mask <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> tb/keypad_debounce_repeat_queue_core_tb.sv
// stimulus and verdict for the keypad debounce and event queue core
module keypad_debounce_repeat_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  kdrq_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready = 1'b0;
  kdrq_pkg::out_t out_data;
  logic           cfg_we;
  logic [1:0]     cfg_index;
  logic [63:0]    cfg_data;
  int             fail_count;
  int             results_pending;

  int          burst_left;
  logic [31:0] now_ms;
  logic [7:0]  held_cols [8];
  int          stall_cnt = 0;
  int          stall_mode = 0;

  keypad_debounce_repeat_queue_core dut (.*);

  keypad_debounce_repeat_queue_checker checker_i (.*);

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stall pattern: a randomly drawn mode sets out_ready
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_cnt % 16) < 12;
    endcase
  end

  // send one transaction, keeping valid up within a burst
  task automatic send(input kdrq_pkg::in_t x);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic op(input logic [1:0] code, input logic [2:0] row, input logic [7:0] cols,
                    input logic [31:0] t);
    kdrq_pkg::in_t x;
    x.operation = code;
    x.scan_row = row;
    x.pressed_columns = cols;
    x.now_ms = t;
    send(x);
  endtask

  // drain, then write all registers while idle
  task automatic configure(input logic [7:0] dm, input logic [31:0] dl,
                           input logic [31:0] iv, input logic [63:0] mask);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= kdrq_pkg::CFG_DEBOUNCE_MAX; cfg_data <= {56'd0, dm};  @(posedge clk);
    cfg_index <= kdrq_pkg::CFG_REPEAT_DELAY; cfg_data <= {32'd0, dl};  @(posedge clk);
    cfg_index <= kdrq_pkg::CFG_REPEAT_INTVL; cfg_data <= {32'd0, iv};  @(posedge clk);
    cfg_index <= kdrq_pkg::CFG_REPEAT_MASK;  cfg_data <= mask;         @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random operations on held key patterns; poll_pct sets how fast the queue drains
  task automatic random_phase(input int n, input int poll_pct);
    int r;
    logic [2:0] row;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      row = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) held_cols[row] ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 39) == 0) held_cols[row] = 8'($urandom);
      now_ms += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 40);
      if (r < poll_pct) op(kdrq_pkg::OP_POLL, row, 8'($urandom), now_ms);
      else if (r < 97) begin
        // mostly clean held patterns, some bounce noise
        if ($urandom_range(0, 7) == 0) op(kdrq_pkg::OP_SCAN, row, 8'($urandom), now_ms);
        else op(kdrq_pkg::OP_SCAN, row, held_cols[row], now_ms);
      end else if (r < 99) op(kdrq_pkg::OP_RELEASE, row, 8'($urandom), now_ms);
      else op(kdrq_pkg::OP_CLEAR, row, 8'($urandom), now_ms);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = $urandom_range(1, 20);
    now_ms = $urandom;
    for (int r = 0; r < 8; r++) held_cols[r] = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fast debounce, immediate repeat, overflow and wrap of time
    configure(8'd1, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    op(kdrq_pkg::OP_POLL, 3'd0, 8'h00, 32'd0);
    op(kdrq_pkg::OP_SCAN, 3'd0, 8'hFF, 32'd0);
    op(kdrq_pkg::OP_SCAN, 3'd7, 8'hFF, 32'hFFFF_FFFF);
    op(kdrq_pkg::OP_SCAN, 3'd0, 8'hFF, 32'd5);
    op(kdrq_pkg::OP_POLL, 3'd0, 8'h00, 32'd5);
    op(kdrq_pkg::OP_POLL, 3'd7, 8'h00, 32'd5);
    op(kdrq_pkg::OP_SCAN, 3'd0, 8'h00, 32'd6);
    op(kdrq_pkg::OP_SCAN, 3'd7, 8'h0F, 32'd7);
    op(kdrq_pkg::OP_SCAN, 3'd7, 8'h00, 32'd8);
    for (int i = 0; i < 4; i++) op(kdrq_pkg::OP_POLL, 3'd1, 8'hFF, 32'd9);
    op(kdrq_pkg::OP_SCAN, 3'd3, 8'hA5, 32'd10);
    op(kdrq_pkg::OP_POLL, 3'd3, 8'h00, 32'd10);
    op(kdrq_pkg::OP_SCAN, 3'd3, 8'hFF, 32'd11);
    op(kdrq_pkg::OP_RELEASE, 3'd3, 8'h00, 32'd12);
    op(kdrq_pkg::OP_SCAN, 3'd3, 8'hFF, 32'd13);
    op(kdrq_pkg::OP_SCAN, 3'd3, 8'h00, 32'd14);
    op(kdrq_pkg::OP_POLL, 3'd3, 8'h00, 32'd15);
    op(kdrq_pkg::OP_CLEAR, 3'd3, 8'h00, 32'd16);
    op(kdrq_pkg::OP_POLL, 3'd3, 8'h00, 32'd17);
    random_phase(200, 20);

    // register reset values written back, with wide slow debounce in between
    configure(kdrq_pkg::DEBOUNCE_RST, kdrq_pkg::DELAY_RST, kdrq_pkg::INTVL_RST,
              {$urandom, $urandom});
    random_phase(300, 30);
    configure(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {$urandom, $urandom});
    random_phase(200, 10);
    // lowered debounce leaves integrators above the new level
    configure(8'd0, 32'd10, 32'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(300, 45);
    configure(8'd2, 32'd20, 32'd5, {$urandom, $urandom});
    random_phase(250, 15);
    configure(8'($urandom_range(1, 6)), $urandom_range(0, 60), $urandom_range(0, 20),
              {$urandom, $urandom});
    random_phase(280, 35);

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // timeout
  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
